@@ hw/rtl/arcpoly_pkg.sv @@
// Shared types, constants and the CORDIC arctangent table for the arc to polyline generator.
// No dependencies; every other file imports this package.
package arcpoly_pkg;

	localparam int COORD_W = 32;
	localparam int RAD_W = 31;
	localparam int ERR_W = 31;
	localparam int SEG_W = 6;
	localparam int SPAN_W = 33;
	localparam int ANG_W = 36;
	localparam int CW_W = 50;
	localparam int ATAN_IDX_W = 5;

	localparam int MAX_SEG_DEF = 60;
	localparam int STEPS_DEF = 24;

	localparam logic [29:0] KINV_Q30 = 30'd652032874;
	localparam logic signed [CW_W-1:0] Q30_ONE = CW_W'(64'sd1073741824);

	localparam logic signed [ANG_W-1:0] ANG_QUARTER = ANG_W'(64'sh4000_0000);
	localparam logic signed [ANG_W-1:0] ANG_HALF = ANG_W'(64'sh8000_0000);
	localparam logic signed [ANG_W-1:0] ANG_TURN = ANG_W'(64'sh1_0000_0000);

	localparam logic CFG_MIN_SEGMENTS = 1'b0;
	localparam logic CFG_ERR_LIMIT = 1'b1;

	typedef struct packed {
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
		logic signed [COORD_W-1:0] center_x;
		logic signed [COORD_W-1:0] center_y;
		logic [RAD_W-1:0] radius;
		logic cw;
	} arc_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] vertex_x;
		logic signed [COORD_W-1:0] vertex_y;
		logic last_vertex;
	} vertex_t;

	typedef struct packed {
		logic [SEG_W-1:0] min_segments;
		logic [ERR_W-1:0] err_limit;
	} cfg_t;

	// one arc, fully classified, waiting for vertex generation
	typedef struct packed {
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
		logic signed [COORD_W-1:0] center_x;
		logic signed [COORD_W-1:0] center_y;
		logic signed [ANG_W-1:0] alpha;
		logic cw;
		logic [SPAN_W-1:0] step_q;
		logic [SEG_W-1:0] step_r;
		logic [SEG_W-1:0] pts;
		logic signed [CW_W-1:0] x0;
	} job_t;

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic [31:0] atan_tab(input logic [ATAN_IDX_W-1:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0: v = 32'h20000000;
			5'd1: v = 32'h12E4051D;
			5'd2: v = 32'h09FB385B;
			5'd3: v = 32'h051111D4;
			5'd4: v = 32'h028B0D43;
			5'd5: v = 32'h0145D7E1;
			5'd6: v = 32'h00A2F61E;
			5'd7: v = 32'h00517C55;
			5'd8: v = 32'h0028BE53;
			5'd9: v = 32'h00145F2E;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2F9;
			5'd15: v = 32'h0000517C;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A2F;
			5'd19: v = 32'h00000517;
			5'd20: v = 32'h0000028B;
			5'd21: v = 32'h00000145;
			5'd22: v = 32'h000000A2;
			5'd23: v = 32'h00000051;
			5'd24: v = 32'h00000028;
			5'd25: v = 32'h00000014;
			5'd26: v = 32'h0000000A;
			5'd27: v = 32'h00000005;
			5'd28: v = 32'h00000002;
			5'd29: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

@@ hw/rtl/arc_to_polyline_generator.sv @@
// Arc to polyline generator: one arc in, start point, inner vertices and end point out.
// Front setup finds both end angles, then refines the segment count while an error limit is set.
// Back: first vertex the cycle after the arc reaches it, then the inner vertices one at a time
// (one rotation unit, used for every inner vertex), end point the cycle after the vertex before it.
// A two-word queue lets the next arc be set up while the current one is emitted.
// Reset (arst_n low) empties the queue, idles both parts, min_segments to 32, error limit to 0.
module arc_to_polyline_generator #(
	parameter int MAX_SEGMENTS = arcpoly_pkg::MAX_SEG_DEF,
	parameter int CORDIC_STEPS = arcpoly_pkg::STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  arcpoly_pkg::arc_t arc,
	output arcpoly_pkg::vertex_t vertex,
	output logic vertex_valid,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_index,
	input  logic [arcpoly_pkg::ERR_W-1:0] cfg_data
);
	import arcpoly_pkg::*;

	cfg_t cfg_q;
	job_t wr_job, rd_job;
	logic push, full, pop, empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_segments <= SEG_W'(32);
			cfg_q.err_limit <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MIN_SEGMENTS: cfg_q.min_segments <= cfg_data[SEG_W-1:0];
				CFG_ERR_LIMIT: cfg_q.err_limit <= cfg_data;
				default: ;
			endcase
		end
	end

	arcpoly_front #(.MAX_SEG(MAX_SEGMENTS), .STEPS(CORDIC_STEPS)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .arc(arc),
		.cfg(cfg_q), .job(wr_job), .push(push), .full(full)
	);

	arcpoly_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wr_job(wr_job), .full(full),
		.pop(pop), .rd_job(rd_job), .empty(empty)
	);

	arcpoly_back #(.STEPS(CORDIC_STEPS)) u_back (
		.clk(clk), .arst_n(arst_n), .job(rd_job), .empty(empty), .pop(pop),
		.vertex(vertex), .vertex_valid(vertex_valid)
	);

endmodule

@@ hw/rtl/arcpoly_cordic.sv @@
// Iterative CORDIC, one micro-rotation per cycle, vectoring (atan2) or rotation mode.
// Depends on arcpoly_pkg.
module arcpoly_cordic #(
	parameter int STEPS = arcpoly_pkg::STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic vec,
	input  logic signed [arcpoly_pkg::CW_W-1:0] x_in,
	input  logic signed [arcpoly_pkg::CW_W-1:0] y_in,
	input  logic signed [arcpoly_pkg::ANG_W-1:0] z_in,
	output logic done,
	output logic signed [arcpoly_pkg::CW_W-1:0] x_out,
	output logic signed [arcpoly_pkg::CW_W-1:0] y_out,
	output logic signed [arcpoly_pkg::ANG_W-1:0] z_out
);
	import arcpoly_pkg::*;

	localparam int IW = $clog2(STEPS);

	logic run_q, done_q, vec_q, neg_q;
	logic [IW-1:0] i_q;
	logic signed [CW_W-1:0] x_q, y_q, x_f, y_f, x_sh, y_sh;
	logic signed [ANG_W-1:0] z_q, z_w, z_f, atan_v;
	logic neg_f, dir;

	// input fold: vectoring into the right half plane, rotation into +/- a quarter turn
	always_comb begin
		x_f = x_in;
		y_f = y_in;
		z_f = '0;
		neg_f = 1'b0;
		z_w = ANG_W'(signed'(z_in[31:0]));
		if (vec) begin
			if (x_in < 0) begin
				z_f = (y_in >= 0) ? ANG_HALF : -ANG_HALF;
				x_f = -x_in;
				y_f = -y_in;
			end
		end else begin
			z_f = z_w;
			if (z_w > ANG_QUARTER) begin
				z_f = z_w - ANG_HALF;
				neg_f = 1'b1;
			end else if (z_w < -ANG_QUARTER) begin
				z_f = z_w + ANG_HALF;
				neg_f = 1'b1;
			end
		end
	end

	assign x_sh = x_q >>> i_q;
	assign y_sh = y_q >>> i_q;
	assign atan_v = ANG_W'(atan_tab(ATAN_IDX_W'(i_q)));
	// dir high: turn anticlockwise
	assign dir = vec_q ? (y_q < 0) : (z_q >= 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			i_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				i_q <= '0;
			end else if (run_q) begin
				if (i_q == IW'(STEPS - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
				i_q <= i_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x_f;
			y_q <= y_f;
			z_q <= z_f;
			neg_q <= neg_f;
			vec_q <= vec;
		end else if (run_q) begin
			if (dir) begin
				x_q <= x_q - y_sh;
				y_q <= y_q + x_sh;
				z_q <= z_q - atan_v;
			end else begin
				x_q <= x_q + y_sh;
				y_q <= y_q - x_sh;
				z_q <= z_q + atan_v;
			end
		end
	end

	assign done = done_q;
	assign x_out = neg_q ? -x_q : x_q;
	assign y_out = neg_q ? -y_q : y_q;
	assign z_out = z_q;

endmodule

@@ hw/rtl/arcpoly_queue.sv @@
// Two-word queue of classified arcs between the front and back parts.
// Depends on arcpoly_pkg.
module arcpoly_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  arcpoly_pkg::job_t wr_job,
	output logic full,
	input  logic pop,
	output arcpoly_pkg::job_t rd_job,
	output logic empty
);
	import arcpoly_pkg::*;

	job_t slot_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= wr_job;
	end

	assign rd_job = slot_q[rd_q];
	assign full = cnt_q[1];
	assign empty = (cnt_q == 2'd0);

endmodule

@@ hw/rtl/arcpoly_front.sv @@
// Front part: takes an arc, finds its end angles, span, segment count and angle step.
// Depends on arcpoly_pkg and arcpoly_cordic.
module arcpoly_front #(
	parameter int MAX_SEG = arcpoly_pkg::MAX_SEG_DEF,
	parameter int STEPS = arcpoly_pkg::STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  arcpoly_pkg::arc_t arc,
	input  arcpoly_pkg::cfg_t cfg,
	output arcpoly_pkg::job_t job,
	output logic push,
	input  logic full
);
	import arcpoly_pkg::*;

	localparam int PW = SEG_W + SPAN_W - 1;
	localparam logic [SEG_W-1:0] SMAX = SEG_W'(MAX_SEG);

	typedef enum logic [12:0] {
		F_IDLE = 13'b0000000000001,
		F_ATA  = 13'b0000000000010,
		F_ATB  = 13'b0000000000100,
		F_WRAP = 13'b0000000001000,
		F_SDIV = 13'b0000000010000,
		F_SRS  = 13'b0000000100000,
		F_SROT = 13'b0000001000000,
		F_SMUL = 13'b0000010000000,
		F_SCMP = 13'b0000100000000,
		F_PMUL = 13'b0001000000000,
		F_PDIV = 13'b0010000000000,
		F_X0   = 13'b0100000000000,
		F_PUSH = 13'b1000000000000
	} fstate_t;

	fstate_t state_q;
	arc_t item_q;
	logic signed [ANG_W-1:0] alpha_q, beta_q, a_w, b_w, diff_w;
	logic [SPAN_W-1:0] span_q;
	logic [SEG_W-1:0] s_q, s_clamp, s_next, pts_w, pts_q;
	logic [SEG_W:0] s_sum;
	logic [31:0] d_q;
	logic [62:0] prod_q;
	logic [PW-1:0] pmul_w;
	logic signed [CW_W-1:0] x0_q;

	logic [SPAN_W-1:0] div_n_q, div_n_nx;
	logic [SEG_W-1:0] div_rem_q, div_d_q;
	logic [SEG_W:0] rem_sh, rem_nx;
	logic div_ge;
	logic [5:0] div_cnt_q;

	logic cor_start, cor_vec, c_done;
	logic signed [CW_W-1:0] cor_x, cor_y, c_x;
	logic signed [ANG_W-1:0] cor_z, c_z;

	arcpoly_cordic #(.STEPS(STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cor_start), .vec(cor_vec),
		.x_in(cor_x), .y_in(cor_y), .z_in(cor_z),
		.done(c_done), .x_out(c_x), .y_out(), .z_out(c_z)
	);

	always_comb begin
		cor_start = 1'b0;
		cor_vec = 1'b1;
		cor_x = CW_W'(arc.start_x) - CW_W'(arc.center_x);
		cor_y = CW_W'(arc.start_y) - CW_W'(arc.center_y);
		cor_z = '0;
		case (state_q)
			F_IDLE: cor_start = start;
			F_ATA: begin
				cor_start = c_done;
				cor_x = CW_W'(item_q.end_x) - CW_W'(item_q.center_x);
				cor_y = CW_W'(item_q.end_y) - CW_W'(item_q.center_y);
			end
			F_SRS: begin
				cor_start = 1'b1;
				cor_vec = 1'b0;
				cor_x = CW_W'(KINV_Q30);
				cor_y = '0;
				cor_z = ANG_W'(div_n_q);
			end
			default: cor_start = 1'b0;
		endcase
	end

	// direction wrap and span
	always_comb begin
		a_w = alpha_q;
		b_w = beta_q;
		if (item_q.cw) begin
			if (a_w < b_w) a_w = a_w + ANG_TURN;
		end else begin
			if (b_w < a_w) b_w = b_w + ANG_TURN;
			if (item_q.start_x == item_q.end_x && item_q.start_y == item_q.end_y)
				b_w = a_w + ANG_TURN;
		end
		diff_w = (a_w > b_w) ? a_w - b_w : b_w - a_w;
	end

	always_comb begin
		if (cfg.min_segments == '0) s_clamp = SEG_W'(1);
		else if (cfg.min_segments > SMAX) s_clamp = SMAX;
		else s_clamp = cfg.min_segments;
		s_sum = (SEG_W + 1)'(s_q) + (SEG_W + 1)'(4);
		s_next = (s_sum > (SEG_W + 1)'(MAX_SEG)) ? SMAX : s_sum[SEG_W-1:0];
		pmul_w = PW'(s_q) * PW'(span_q) + (PW'(1) << 31);
		pts_w = pmul_w[PW-1:32];
	end

	// restoring divider, one quotient bit a cycle
	always_comb begin
		rem_sh = {div_rem_q, div_n_q[SPAN_W-1]};
		div_ge = rem_sh >= {1'b0, div_d_q};
		rem_nx = div_ge ? rem_sh - {1'b0, div_d_q} : rem_sh;
		div_n_nx = {div_n_q[SPAN_W-2:0], div_ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: if (start) state_q <= F_ATA;
				F_ATA:  if (c_done) state_q <= F_ATB;
				F_ATB:  if (c_done) state_q <= F_WRAP;
				F_WRAP: begin
					if (cfg.err_limit != '0 && s_q < SMAX) state_q <= F_SDIV;
					else state_q <= F_PMUL;
				end
				F_SDIV: if (div_cnt_q == 6'd1) state_q <= F_SRS;
				F_SRS:  state_q <= F_SROT;
				F_SROT: if (c_done) state_q <= F_SMUL;
				F_SMUL: state_q <= F_SCMP;
				F_SCMP: begin
					if (prod_q[62:30] > SPAN_W'(cfg.err_limit) && s_next < SMAX)
						state_q <= F_SDIV;
					else
						state_q <= F_PMUL;
				end
				F_PMUL: state_q <= F_PDIV;
				F_PDIV: if (div_cnt_q == 6'd1) state_q <= F_X0;
				F_X0:   state_q <= F_PUSH;
				F_PUSH: if (!full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (div_cnt_q != '0) div_cnt_q <= div_cnt_q - 1'b1;
		if (state_q == F_SDIV || state_q == F_PDIV) begin
			div_n_q <= div_n_nx;
			div_rem_q <= rem_nx[SEG_W-1:0];
		end
		case (state_q)
			F_IDLE: begin
				div_cnt_q <= '0;
				if (start) begin
					item_q <= arc;
					s_q <= s_clamp;
				end
			end
			F_ATA: if (c_done) alpha_q <= c_z;
			F_ATB: if (c_done) beta_q <= c_z;
			F_WRAP: begin
				alpha_q <= a_w;
				span_q <= diff_w[SPAN_W-1:0];
				div_n_q <= SPAN_W'(1) << 31;
				div_rem_q <= '0;
				div_d_q <= s_q;
				div_cnt_q <= 6'(SPAN_W);
			end
			F_SROT: if (c_done) d_q <= (c_x >= Q30_ONE) ? 32'd0 : 32'(Q30_ONE - c_x);
			F_SMUL: prod_q <= 63'(item_q.radius) * 63'(d_q);
			F_SCMP: begin
				if (prod_q[62:30] > SPAN_W'(cfg.err_limit)) s_q <= s_next;
				div_n_q <= SPAN_W'(1) << 31;
				div_rem_q <= '0;
				div_d_q <= s_next;
				div_cnt_q <= 6'(SPAN_W);
			end
			F_PMUL: begin
				pts_q <= (pts_w == '0) ? SEG_W'(1) : pts_w;
				div_n_q <= span_q;
				div_rem_q <= '0;
				div_d_q <= (pts_w == '0) ? SEG_W'(1) : pts_w;
				div_cnt_q <= 6'(SPAN_W);
			end
			F_X0: x0_q <= CW_W'((61'(item_q.radius) * 61'(KINV_Q30)) >> 14);
			default: ;
		endcase
	end

	assign busy = (state_q != F_IDLE);
	assign push = (state_q == F_PUSH) && !full;

	always_comb begin
		job.start_x = item_q.start_x;
		job.start_y = item_q.start_y;
		job.end_x = item_q.end_x;
		job.end_y = item_q.end_y;
		job.center_x = item_q.center_x;
		job.center_y = item_q.center_y;
		job.alpha = alpha_q;
		job.cw = item_q.cw;
		job.step_q = div_n_q;
		job.step_r = div_rem_q;
		job.pts = pts_q;
		job.x0 = x0_q;
	end

endmodule

@@ hw/rtl/arcpoly_back.sv @@
// Back part: emits the start point, the rotated inner vertices and the end point of one arc.
// Depends on arcpoly_pkg and arcpoly_cordic.
module arcpoly_back #(
	parameter int STEPS = arcpoly_pkg::STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  arcpoly_pkg::job_t job,
	input  logic empty,
	output logic pop,
	output arcpoly_pkg::vertex_t vertex,
	output logic vertex_valid
);
	import arcpoly_pkg::*;

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_STEP = 3'b010,
		B_WAIT = 3'b100
	} bstate_t;

	localparam logic signed [CW_W-1:0] C_MAX = CW_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
	localparam logic signed [CW_W-1:0] C_MIN = -C_MAX - CW_W'(1);
	localparam logic signed [CW_W-1:0] HALF_LSB = CW_W'(32768);

	bstate_t state_q;
	job_t job_q;
	vertex_t vtx_q;
	logic vld_q;
	logic [SEG_W-1:0] i_q, rem_n;
	logic [SEG_W:0] rem_sum;
	logic [SEG_W-1:0] rem_q;
	logic carry;
	logic [SPAN_W-1:0] d_q, d_n;
	logic signed [ANG_W-1:0] ang;
	logic signed [CW_W-1:0] c_x, c_y, sum_x, sum_y;
	logic c_done, cor_start;

	function automatic logic signed [COORD_W-1:0] sat(input logic signed [CW_W-1:0] v);
		logic signed [COORD_W-1:0] r;
		if (v > C_MAX) r = C_MAX[COORD_W-1:0];
		else if (v < C_MIN) r = C_MIN[COORD_W-1:0];
		else r = v[COORD_W-1:0];
		return r;
	endfunction

	// running floor(span * i / pts) as quotient plus remainder carry
	always_comb begin
		rem_sum = (SEG_W + 1)'(rem_q) + (SEG_W + 1)'(job_q.step_r);
		carry = rem_sum >= (SEG_W + 1)'(job_q.pts);
		rem_n = carry ? SEG_W'(rem_sum - (SEG_W + 1)'(job_q.pts)) : rem_sum[SEG_W-1:0];
		d_n = d_q + job_q.step_q + SPAN_W'(carry);
		ang = job_q.cw ? job_q.alpha - ANG_W'(d_n) : job_q.alpha + ANG_W'(d_n);
		cor_start = (state_q == B_STEP) && (i_q < job_q.pts);
		sum_x = CW_W'(job_q.center_x) + ((c_x + HALF_LSB) >>> 16);
		sum_y = CW_W'(job_q.center_y) + ((c_y + HALF_LSB) >>> 16);
	end

	arcpoly_cordic #(.STEPS(STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cor_start), .vec(1'b0),
		.x_in(job_q.x0), .y_in('0), .z_in(ang),
		.done(c_done), .x_out(c_x), .y_out(c_y), .z_out()
	);

	assign pop = (state_q == B_IDLE) && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			vld_q <= 1'b0;
		end else begin
			vld_q <= 1'b0;
			case (state_q)
				B_IDLE: if (!empty) begin
					state_q <= B_STEP;
					vld_q <= 1'b1;
				end
				B_STEP: begin
					if (i_q < job_q.pts) begin
						state_q <= B_WAIT;
					end else begin
						state_q <= B_IDLE;
						vld_q <= 1'b1;
					end
				end
				B_WAIT: if (c_done) begin
					state_q <= B_STEP;
					vld_q <= 1'b1;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (!empty) begin
					job_q <= job;
					vtx_q <= '{vertex_x: job.start_x, vertex_y: job.start_y, last_vertex: 1'b0};
				end
				i_q <= SEG_W'(1);
				d_q <= '0;
				rem_q <= '0;
			end
			B_STEP: begin
				if (i_q < job_q.pts) begin
					d_q <= d_n;
					rem_q <= rem_n;
				end else begin
					vtx_q <= '{vertex_x: job_q.end_x, vertex_y: job_q.end_y, last_vertex: 1'b1};
				end
			end
			B_WAIT: if (c_done) begin
				vtx_q <= '{vertex_x: sat(sum_x), vertex_y: sat(sum_y), last_vertex: 1'b0};
				i_q <= i_q + 1'b1;
			end
			default: ;
		endcase
	end

	assign vertex = vtx_q;
	assign vertex_valid = vld_q;

endmodule

@@ tb/tb_arc_to_polyline_generator.sv @@
// Self-checking testbench for arc_to_polyline_generator: random and directed arcs,
// predicted vertex by vertex. Depends on arcpoly_pkg and the generator RTL only.
`timescale 1ns / 100ps

module tb_arc_to_polyline_generator;
	import arcpoly_pkg::*;

	localparam int NSEG = 60;
	localparam int NSTEP = 24;
	localparam longint TURN = 64'sd1 << 32;
	localparam longint HALF = 64'sd1 << 31;
	localparam longint QUART = 64'sd1 << 30;
	localparam longint KQ30 = 64'sd652032874;
	localparam longint LIMIT = 8000000;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	arc_t arc = '0;
	vertex_t vertex;
	logic vertex_valid;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic cfg_index = CFG_MIN_SEGMENTS;
	logic [ERR_W-1:0] cfg_data = '0;

	arc_to_polyline_generator dut (.*);

	initial forever #6 clk = ~clk;

	// angle table, atan(2^-i) in 2^-32 turn
	function automatic longint arctab(int i);
		longint t[24] = '{64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4,
			64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53,
			64'h00145F2E, 64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3,
			64'h0000A2F9, 64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F,
			64'h00000517, 64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051};
		return t[i];
	endfunction

	function automatic longint vec_angle(longint y, longint x);
		longint z, dx, dy;
		z = 0;
		if (x < 0) begin
			z = (y >= 0) ? HALF : -HALF;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < NSTEP; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += arctab(i);
			end else begin
				x -= dx; y += dy; z -= arctab(i);
			end
		end
		return z;
	endfunction

	function automatic void rotate(input longint x0, input longint a, output longint cx,
		output longint sy);
		longint z, x, y, dx, dy;
		bit neg;
		z = a & 64'hFFFFFFFF;
		if (z >= HALF) z -= TURN;
		x = x0; y = 0; neg = 0;
		if (z > QUART) begin
			z -= HALF; neg = 1;
		end else if (z < -QUART) begin
			z += HALF; neg = 1;
		end
		for (int i = 0; i < NSTEP; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= arctab(i);
			end else begin
				x += dx; y -= dy; z += arctab(i);
			end
		end
		cx = neg ? -x : x;
		sy = neg ? -y : y;
	endfunction

	function automatic longint clamp_coord(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	class vertex_scoreboard;
		vertex_t pending[$];
		int unsigned min_seg = 32;
		longint unsigned arc_err = 0;
		int fails = 0;
		int arcs = 0;
		int words = 0;

		function void add_word(vertex_t w);
			pending.insert(pending.size(), w);
		endfunction

		function void note_arc(arc_t a);
			longint x1, y1, x2, y2, xc, yc, alpha, beta, s, x0, cx, sy, c, d, dd, ang;
			longint unsigned span, pts, r, e;
			vertex_t v;
			x1 = a.start_x; y1 = a.start_y; x2 = a.end_x; y2 = a.end_y;
			xc = a.center_x; yc = a.center_y; r = a.radius;
			alpha = vec_angle(y1 - yc, x1 - xc);
			beta = vec_angle(y2 - yc, x2 - xc);
			if (a.cw) begin
				if (alpha < beta) alpha += TURN;
			end else begin
				if (beta < alpha) beta += TURN;
				if (x1 == x2 && y1 == y2) beta = alpha + TURN;
			end
			span = (alpha > beta) ? alpha - beta : beta - alpha;
			s = min_seg;
			if (s < 1) s = 1;
			if (s > NSEG) s = NSEG;
			if (arc_err > 0) begin
				while (s < NSEG) begin
					rotate(KQ30, HALF / s, c, sy);
					d = (c >= QUART) ? 0 : QUART - c;
					e = (r * longint'(d)) >> 30;
					if (e <= arc_err) break;
					s += 4;
					if (s > NSEG) s = NSEG;
				end
			end
			pts = (longint'(s) * span + (64'd1 << 31)) >> 32;
			if (pts < 1) pts = 1;
			add_word(vertex_t'{a.start_x, a.start_y, 1'b0});
			x0 = (r * longint'(KQ30)) >> 14;
			for (longint unsigned i = 1; i < pts; i++) begin
				dd = (span * i) / pts;
				ang = a.cw ? alpha - dd : alpha + dd;
				rotate(x0, ang, cx, sy);
				v.vertex_x = COORD_W'(clamp_coord(xc + ((cx + 32768) >>> 16)));
				v.vertex_y = COORD_W'(clamp_coord(yc + ((sy + 32768) >>> 16)));
				v.last_vertex = 0;
				add_word(v);
			end
			add_word(vertex_t'{a.end_x, a.end_y, 1'b1});
			arcs++;
		endfunction

		function void check_vertex(vertex_t got);
			vertex_t exp;
			words++;
			if (pending.size() == 0) begin
				$error("unexpected vertex %h", got);
				fails++;
				return;
			end
			exp = pending.pop_front();
			if (got.vertex_x !== exp.vertex_x) begin
				$error("vertex_x exp %0d got %0d", exp.vertex_x, got.vertex_x); fails++;
			end
			if (got.vertex_y !== exp.vertex_y) begin
				$error("vertex_y exp %0d got %0d", exp.vertex_y, got.vertex_y); fails++;
			end
			if (got.last_vertex !== exp.last_vertex) begin
				$error("last_vertex exp %0b got %0b", exp.last_vertex, got.last_vertex); fails++;
			end
		endfunction
	endclass

	vertex_scoreboard sb = new();
	longint cycles = 0;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && vertex_valid) sb.check_vertex(vertex);
		if (cycles > LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 3);
		repeat (n) @(posedge clk);
	endtask

	task automatic send_arc(arc_t a);
		start <= 1;
		arc <= a;
		do @(posedge clk); while (busy);
		sb.note_arc(a);
		start <= 0;
		arc <= arc_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		// the front is busy for many cycles after a word, so this costs no rate
		@(posedge clk);
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (2 * NSTEP + 200) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [ERR_W-1:0] val);
		drain();
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		if (idx == CFG_MIN_SEGMENTS) sb.min_seg = val[SEG_W-1:0];
		else sb.arc_err = val;
	endtask

	// small coordinates around a centre keep vertices sane; start and end lie within rad of it on each axis
	function automatic arc_t circle_arc(int rad, bit dir);
		arc_t a;
		longint cx, cy;
		int t1, t2;
		cx = $signed($urandom_range(0, 2000000)) - 1000000;
		cy = $signed($urandom_range(0, 2000000)) - 1000000;
		t1 = $urandom_range(0, 7);
		t2 = $urandom_range(0, 7);
		a.center_x = COORD_W'(cx); a.center_y = COORD_W'(cy);
		a.start_x = COORD_W'(cx + ((t1 % 3 == 0) ? rad : (t1 % 3 == 1) ? -rad :
			$urandom_range(0, rad)));
		a.start_y = COORD_W'(cy + ((t1 > 3) ? rad : -$signed($urandom_range(0, rad))));
		if ($urandom_range(0, 5) == 0) begin
			a.end_x = a.start_x; a.end_y = a.start_y;
		end else begin
			a.end_x = COORD_W'(cx + ((t2 % 2) ? rad : -$signed($urandom_range(0, rad))));
			a.end_y = COORD_W'(cy + ((t2 > 3) ? -rad : $urandom_range(0, rad)));
		end
		a.radius = RAD_W'(rad);
		a.cw = dir;
		return a;
	endfunction

	initial begin
		arc_t a;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: zero vector, negative x axis, full circle, short arc, extremes
		send_arc('{0, 0, 0, 0, 0, 0, 0, 1'b0});
		send_arc('{-4096, 0, 4096, 0, 0, 0, 4096, 1'b1});
		send_arc('{-4096, 0, 4096, 0, 0, 0, 4096, 1'b0});
		send_arc('{40960, 0, 40960, 0, 0, 0, 40960, 1'b1});
		send_arc('{40960, 0, 40960, 1, 0, 0, 40960, 1'b0});
		send_arc('{40960, 1, 40960, 0, 0, 0, 40960, 1'b0});
		send_arc('{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
			32'h7FFFFFFF, 32'h80000000, 31'h7FFFFFFF, 1'b1});
		send_arc('{32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
			32'h80000000, 32'h7FFFFFFF, 31'h7FFFFFFF, 1'b0});
		send_arc('{32'hFFFFFFFF, 0, 0, 32'hFFFFFFFF, 0, 0, 31'h40000000, 1'b0});

		write_reg(CFG_MIN_SEGMENTS, 0);
		send_arc(circle_arc(800000, 0));
		write_reg(CFG_MIN_SEGMENTS, 63);
		send_arc(circle_arc(800000, 1));
		send_arc(circle_arc(8000, 0));
		write_reg(CFG_MIN_SEGMENTS, 4);
		write_reg(CFG_ERR_LIMIT, 1);
		send_arc(circle_arc(900000, 0));
		send_arc(circle_arc(0, 1));
		write_reg(CFG_ERR_LIMIT, 31'h7FFFFFFF);
		send_arc(circle_arc(900000, 0));

		for (int ph = 0; ph < 6; ph++) begin
			write_reg(CFG_MIN_SEGMENTS, ERR_W'((ph == 0) ? 60 : $urandom_range(0, 63)));
			write_reg(CFG_ERR_LIMIT, ERR_W'((ph % 3 == 0) ? 0 :
				(ph % 3 == 1) ? $urandom_range(1, 4000) : $urandom));
			for (int k = 0; k < 60; k++) begin
				if ($urandom_range(0, 7) == 0)
					a = arc_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
						$urandom});
				else
					a = circle_arc($urandom_range(0, 3) == 0 ? $urandom_range(0, 4096) :
						$urandom_range(4096, 1000000), $urandom_range(0, 1));
				send_arc(a);
				if (k == 30) drain();
				else if ($urandom_range(0, 2) == 0) idle_gap();
			end
		end
		drain();
		$display("covered %0d arcs and %0d vertices over several segment and error settings",
			sb.arcs, sb.words);
		if (sb.fails == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule
